/* sv/rgb_conv3x3_normalized_macros.svh */
// ----------------------------------------------------------------------------
// rgb_conv3x3_normalized assertion macros
// concurrent assertion wrappers, empty when building for synthesis
// ----------------------------------------------------------------------------
`ifndef RGB_CONV3X3_NORMALIZED_MACROS_SVH
`define RGB_CONV3X3_NORMALIZED_MACROS_SVH
`ifndef SYNTHESIS
// checked outside reset
`define RCN_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// checked on every edge, reset included
`define RCN_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define RCN_ASSERT(lbl, clk, rst, prop, msg)
`define RCN_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/rcn_pkg.sv */
// ----------------------------------------------------------------------------
// rcn_pkg
// shared constants, types and helpers of the 3x3 rgb filter
// ----------------------------------------------------------------------------
package rcn_pkg;
   localparam int MAX_WIDTH     = 2048;
   localparam int MAX_HEIGHT    = 4096;
   localparam int WEIGHT_BITS   = 8;
   localparam int COL_BITS      = $clog2(MAX_WIDTH);
   localparam int ROW_BITS      = $clog2(MAX_HEIGHT);
   localparam int CHAN_BITS     = 8;
   localparam int PIX_BITS      = 3 * CHAN_BITS;
   localparam int FW_BITS       = 12;
   localparam int FH_BITS       = 13;
   localparam int KROW_BITS     = 3 * WEIGHT_BITS;
   localparam int CSR_DATA_BITS = (KROW_BITS > FH_BITS) ? KROW_BITS : FH_BITS;
   localparam int CSR_ADDR_BITS = 3;
   localparam int TAPS          = 9;
   localparam int TAP_BITS      = $clog2(TAPS);
   // product of an unsigned channel and a signed weight, nine of them summed
   localparam int PROD_BITS     = CHAN_BITS + WEIGHT_BITS + 1;
   localparam int ACC_BITS      = PROD_BITS + 4;
   localparam int REM_BITS      = ACC_BITS - 1;
   localparam int FAC_BITS      = WEIGHT_BITS + 4;
   localparam int QUO_BITS      = CHAN_BITS + 1;
   localparam int STEP_BITS     = $clog2(QUO_BITS);
   localparam int QUEUE_DEPTH   = 4;
   localparam int QPTR_BITS     = $clog2(QUEUE_DEPTH);
   localparam logic [CHAN_BITS-1:0] CHAN_MAX = CHAN_BITS'(255);

   localparam logic [FW_BITS-1:0] RESET_WIDTH  = FW_BITS'(640);
   localparam logic [FH_BITS-1:0] RESET_HEIGHT = FH_BITS'(480);
   localparam logic [KROW_BITS-1:0] RESET_KTOP = KROW_BITS'(1) << (2 * WEIGHT_BITS);
   localparam logic [KROW_BITS-1:0] RESET_KMID = KROW_BITS'(1) << WEIGHT_BITS;
   localparam logic [KROW_BITS-1:0] RESET_KBOT = '0;

   typedef enum logic [CSR_ADDR_BITS-1:0] {
      CSR_FRAME_WIDTH  = 3'd0,
      CSR_FRAME_HEIGHT = 3'd1,
      CSR_KERNEL_TOP   = 3'd2,
      CSR_KERNEL_MID   = 3'd3,
      CSR_KERNEL_BOT   = 3'd4
   } csr_index_type;

   typedef struct packed {
      logic [FW_BITS-1:0]              frame_width;
      logic [FH_BITS-1:0]              frame_height;
      logic [2:0][KROW_BITS-1:0]       kernel;     // index 0 is the top row
   } cfg_type;

   // one output pixel to compute: nine window pixels, row-major from top left
   typedef struct packed {
      logic [TAPS-1:0][PIX_BITS-1:0]   pix;
      logic [COL_BITS-1:0]             col;
      logic [ROW_BITS-1:0]             row;
      logic                            done;
   } job_type;

   typedef struct packed {
      logic push;
      logic pop;
      logic full;
      logic empty;
   } qctl_type;

   function automatic logic signed [WEIGHT_BITS-1:0] weight_of(
      input logic [KROW_BITS-1:0] krow,
      input logic [1:0]           c);
      logic signed [WEIGHT_BITS-1:0] w;
      case (c)
         2'd0: w = krow[3*WEIGHT_BITS-1:2*WEIGHT_BITS];
         2'd1: w = krow[2*WEIGHT_BITS-1:WEIGHT_BITS];
         default: w = krow[WEIGHT_BITS-1:0];
      endcase
      return w;
   endfunction
endpackage

/* sv/rcn_ram.sv */
// ----------------------------------------------------------------------------
// rcn_ram
// simple dual-port ram, one write port, one registered read port
// ----------------------------------------------------------------------------
module rcn_ram #(
   parameter int WIDTH = 24,
   parameter int DEPTH = 2048
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;
endmodule

/* sv/rcn_front.sv */
// ----------------------------------------------------------------------------
// rcn_front
// takes pixels, keeps the line stores and the window, queues output jobs
// ----------------------------------------------------------------------------
module rcn_front import rcn_pkg::*; (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [FW_BITS-1:0]   frame_width,
   input  logic [FH_BITS-1:0]   frame_height,
   input  logic                 pix_valid,
   output logic                 pix_ready,
   input  logic [PIX_BITS-1:0]  pix,
   input  logic                 q_full,
   output logic                 q_push,
   output job_type              q_job
);
   typedef enum logic [2:0] {
      F_IDLE = 3'b001,
      F_LOAD = 3'b010,
      F_EMIT = 3'b100
   } fstate_type;

   fstate_type state_ff, state_in;
   logic [COL_BITS-1:0] col_ff, col_in, x_ff, wl_ff, x_cur, wl_cur;
   logic [ROW_BITS-1:0] row_ff, row_in, y_ff, hl_ff, y_cur, hl_cur;
   logic [PIX_BITS-1:0] pix_ff;
   logic [3:0]          mask_ff, mask_in;
   logic [2:0][2:0][PIX_BITS-1:0] win_ff;   // [column oldest..newest][row top..bottom]
   logic [PIX_BITS-1:0] a_rd, b_rd;
   logic                st_we;
   logic [1:0]          k;
   logic [1:0]          rsel [3];
   logic [1:0]          csel [3];

   // effective last column and row of the frame
   always_comb begin
      if (frame_width == '0) begin
         wl_cur = '0;
      end else if (32'(frame_width) > MAX_WIDTH) begin
         wl_cur = COL_BITS'(MAX_WIDTH - 1);
      end else begin
         wl_cur = COL_BITS'(frame_width - 1'b1);
      end
      if (frame_height == '0) begin
         hl_cur = '0;
      end else if (32'(frame_height) > MAX_HEIGHT) begin
         hl_cur = ROW_BITS'(MAX_HEIGHT - 1);
      end else begin
         hl_cur = ROW_BITS'(frame_height - 1'b1);
      end
      x_cur = (col_ff > wl_cur) ? wl_cur : col_ff;
      y_cur = (row_ff > hl_cur) ? hl_cur : row_ff;
   end

   assign pix_ready = (state_ff == F_IDLE);
   assign st_we     = (state_ff == F_LOAD);

   rcn_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_store_a (
      .clock (clock),
      .we    (st_we),
      .waddr (x_ff),
      .wdata (pix_ff),
      .raddr (x_cur),
      .rdata (a_rd)
   );

   rcn_ram #(.WIDTH(PIX_BITS), .DEPTH(MAX_WIDTH)) u_store_b (
      .clock (clock),
      .we    (st_we),
      .waddr (x_ff),
      .wdata (a_rd),
      .raddr (x_cur),
      .rdata (b_rd)
   );

   // job order: row above mid, row above edge, last row mid, last row edge
   always_comb begin
      if (mask_ff[0]) begin
         k = 2'd0;
      end else if (mask_ff[1]) begin
         k = 2'd1;
      end else if (mask_ff[2]) begin
         k = 2'd2;
      end else begin
         k = 2'd3;
      end
      if (k[1]) begin
         rsel[0] = (y_ff == '0) ? 2'd2 : 2'd1;
         rsel[1] = 2'd2;
      end else begin
         rsel[0] = (y_ff == ROW_BITS'(1)) ? 2'd1 : 2'd0;
         rsel[1] = 2'd1;
      end
      rsel[2] = 2'd2;
      if (k[0]) begin
         csel[0] = (x_ff == '0) ? 2'd2 : 2'd1;
         csel[1] = 2'd2;
      end else begin
         csel[0] = (x_ff == COL_BITS'(1)) ? 2'd1 : 2'd0;
         csel[1] = 2'd1;
      end
      csel[2] = 2'd2;
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            q_job.pix[r*3+c] = win_ff[csel[c]][rsel[r]];
         end
      end
      q_job.col  = k[0] ? wl_ff : x_ff - 1'b1;
      q_job.row  = k[1] ? y_ff : y_ff - 1'b1;
      q_job.done = k[1] & k[0];
   end

   assign q_push = (state_ff == F_EMIT) && (mask_ff != '0) && !q_full;

   always_comb begin
      state_in = state_ff;
      col_in   = col_ff;
      row_in   = row_ff;
      mask_in  = mask_ff;
      case (state_ff)
         F_IDLE: begin
            if (pix_valid) begin
               state_in = F_LOAD;
            end
         end
         F_LOAD: begin
            mask_in[0] = (y_ff != '0) && (x_ff != '0);
            mask_in[1] = (y_ff != '0) && (x_ff == wl_ff);
            mask_in[2] = (y_ff == hl_ff) && (x_ff != '0);
            mask_in[3] = (y_ff == hl_ff) && (x_ff == wl_ff);
            if (x_ff >= wl_ff) begin
               col_in = '0;
               row_in = (y_ff >= hl_ff) ? '0 : y_ff + 1'b1;
            end else begin
               col_in = x_ff + 1'b1;
            end
            state_in = F_EMIT;
         end
         F_EMIT: begin
            if (mask_ff == '0) begin
               state_in = F_IDLE;
            end else if (q_push) begin
               mask_in = mask_ff & ~(4'b0001 << k);
            end
         end
         default: state_in = F_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= F_IDLE;
         col_ff   <= '0;
         row_ff   <= '0;
         mask_ff  <= '0;
         win_ff   <= '0;
      end else begin
         state_ff <= state_in;
         col_ff   <= col_in;
         row_ff   <= row_in;
         mask_ff  <= mask_in;
         if (state_ff == F_LOAD) begin
            win_ff[0]    <= win_ff[1];
            win_ff[1]    <= win_ff[2];
            win_ff[2][0] <= b_rd;
            win_ff[2][1] <= a_rd;
            win_ff[2][2] <= pix_ff;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == F_IDLE && pix_valid) begin
         pix_ff <= pix;
         x_ff   <= x_cur;
         y_ff   <= y_cur;
         wl_ff  <= wl_cur;
         hl_ff  <= hl_cur;
      end
   end
endmodule

/* sv/rcn_queue.sv */
// ----------------------------------------------------------------------------
// rcn_queue
// short job queue between the pixel front and the filter back
// ----------------------------------------------------------------------------
module rcn_queue import rcn_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   input  qctl_type ctl_in,
   output logic     full,
   output logic     empty,
   input  job_type  wr_job,
   output job_type  rd_job
);
   job_type               q_ff [QUEUE_DEPTH];
   logic [QPTR_BITS-1:0]  wr_ff, rd_ff;
   logic [QPTR_BITS:0]    cnt_ff, cnt_in;

   assign full   = (cnt_ff == (QPTR_BITS+1)'(QUEUE_DEPTH));
   assign empty  = (cnt_ff == '0);
   assign rd_job = q_ff[rd_ff];

   always_comb begin
      cnt_in = cnt_ff;
      if (ctl_in.push && !ctl_in.pop) begin
         cnt_in = cnt_ff + 1'b1;
      end else if (ctl_in.pop && !ctl_in.push) begin
         cnt_in = cnt_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
         if (ctl_in.push) begin
            wr_ff <= wr_ff + 1'b1;
         end
         if (ctl_in.pop) begin
            rd_ff <= rd_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ctl_in.push) begin
         q_ff[wr_ff] <= wr_job;
      end
   end
endmodule

/* sv/rcn_back.sv */
// ----------------------------------------------------------------------------
// rcn_back
// weighted sum over nine taps, normalizing divide, clamp and output register
// ----------------------------------------------------------------------------
module rcn_back import rcn_pkg::*; (
   input  logic                       clock,
   input  logic                       reset,
   input  logic [2:0][KROW_BITS-1:0]  kernel,
   input  logic                       q_empty,
   input  job_type                    q_job,
   output logic                       q_pop,
   output logic                       rsp_valid,
   input  logic                       rsp_ready,
   output logic [CHAN_BITS-1:0]       rsp_red,
   output logic [CHAN_BITS-1:0]       rsp_green,
   output logic [CHAN_BITS-1:0]       rsp_blue,
   output logic [COL_BITS-1:0]        rsp_col,
   output logic [ROW_BITS-1:0]        rsp_row,
   output logic                       rsp_done
);
   typedef enum logic [3:0] {
      B_IDLE = 4'b0001,
      B_MAC  = 4'b0010,
      B_DIV  = 4'b0100,
      B_DONE = 4'b1000
   } bstate_type;

   bstate_type state_ff, state_in;
   job_type    job_ff;
   logic [TAP_BITS-1:0]  tap_ff;
   logic [1:0]           r_ff, c_ff;
   logic [STEP_BITS-1:0] step_ff;
   logic signed [ACC_BITS-1:0] acc_ff [3];
   logic signed [ACC_BITS-1:0] acc_in [3];
   logic signed [FAC_BITS-1:0] fac_ff, fac_in;
   logic [FAC_BITS-2:0]        dv_ff;
   logic [REM_BITS-1:0]        rem_ff [3];
   logic [REM_BITS-1:0]        rem_in [3];
   logic [QUO_BITS-1:0]        quo_ff [3];
   logic [QUO_BITS-1:0]        quo_in [3];
   logic [REM_BITS-1:0]        trial;
   logic signed [WEIGHT_BITS-1:0] w;
   logic signed [PROD_BITS-1:0]   prod [3];
   logic [PIX_BITS-1:0]        tap_pix;
   logic                       out_load, rsp_valid_ff;
   logic [CHAN_BITS-1:0]       out_ch [3];

   assign w       = weight_of(kernel[r_ff], c_ff);
   assign tap_pix = job_ff.pix[tap_ff];
   assign trial   = REM_BITS'(dv_ff) << step_ff;
   assign q_pop   = (state_ff == B_IDLE) && !q_empty;
   assign out_load = (state_ff == B_DONE) && (!rsp_valid_ff || rsp_ready);

   always_comb begin
      fac_in = fac_ff + FAC_BITS'(w);
      for (int ch = 0; ch < 3; ch++) begin
         // channel 0 is red in the top byte
         prod[ch]   = $signed({1'b0, tap_pix[(2-ch)*CHAN_BITS +: CHAN_BITS]}) * w;
         acc_in[ch] = acc_ff[ch] + ACC_BITS'(prod[ch]);
         rem_in[ch] = rem_ff[ch];
         quo_in[ch] = quo_ff[ch];
         if (rem_ff[ch] >= trial) begin
            rem_in[ch]          = rem_ff[ch] - trial;
            quo_in[ch][step_ff] = 1'b1;
         end
         // a quotient of 256 or more saturates
         out_ch[ch] = quo_ff[ch][QUO_BITS-1] ? CHAN_MAX : quo_ff[ch][CHAN_BITS-1:0];
      end
   end

   always_comb begin
      state_in = state_ff;
      case (state_ff)
         B_IDLE: if (!q_empty) begin
            state_in = B_MAC;
         end
         B_MAC: if (tap_ff == TAP_BITS'(TAPS - 1)) begin
            state_in = B_DIV;
         end
         B_DIV: if (step_ff == '0) begin
            state_in = B_DONE;
         end
         B_DONE: if (out_load) begin
            state_in = B_IDLE;
         end
         default: state_in = B_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= B_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         if (out_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      case (state_ff)
         B_IDLE: begin
            job_ff <= q_job;
            tap_ff <= '0;
            r_ff   <= '0;
            c_ff   <= '0;
            fac_ff <= '0;
            for (int ch = 0; ch < 3; ch++) begin
               acc_ff[ch] <= '0;
            end
         end
         B_MAC: begin
            tap_ff <= tap_ff + 1'b1;
            fac_ff <= fac_in;
            if (c_ff == 2'd2) begin
               c_ff <= '0;
               r_ff <= r_ff + 1'b1;
            end else begin
               c_ff <= c_ff + 1'b1;
            end
            for (int ch = 0; ch < 3; ch++) begin
               acc_ff[ch] <= acc_in[ch];
               // a sum at or below zero truncates to a result of zero
               rem_ff[ch] <= acc_in[ch][ACC_BITS-1] ? '0 : acc_in[ch][REM_BITS-1:0];
               quo_ff[ch] <= '0;
            end
            // divisor below one counts as one
            dv_ff   <= (fac_in[FAC_BITS-1] || fac_in == '0) ?
                       (FAC_BITS-1)'(1) : fac_in[FAC_BITS-2:0];
            step_ff <= STEP_BITS'(QUO_BITS - 1);
         end
         B_DIV: begin
            step_ff <= step_ff - 1'b1;
            for (int ch = 0; ch < 3; ch++) begin
               rem_ff[ch] <= rem_in[ch];
               quo_ff[ch] <= quo_in[ch];
            end
         end
         default: begin
         end
      endcase
      if (out_load) begin
         rsp_red   <= out_ch[0];
         rsp_green <= out_ch[1];
         rsp_blue  <= out_ch[2];
         rsp_col   <= job_ff.col;
         rsp_row   <= job_ff.row;
         rsp_done  <= job_ff.done;
      end
   end

   assign rsp_valid = rsp_valid_ff;
endmodule

/* sv/rgb_conv3x3_normalized.sv */
// ----------------------------------------------------------------------------
// rgb_conv3x3_normalized
// 3x3 rgb convolution with replicated borders, normalized and clamped
// ----------------------------------------------------------------------------
// Pixels come in raster order; each channel is filtered by the signed 3x3
// kernel, divided by the weight sum (one when that sum is below one,
// truncating toward zero) and clamped to 0..255. Output lags one row:
// pixel (x,y) yields (x-1,y-1), the right edge column follows at x = W-1,
// and in the last row that row's pixels follow too, up to four items per
// pixel. The front takes a new pixel only once every job of the last one
// is queued; the back works on one output item at a time, through the
// nine-step multiply-accumulate and the nine-step restoring divide, and
// holds a finished item while the output register awaits the receiver.
// A four-entry job queue lets the front run ahead of the back.
`include "rgb_conv3x3_normalized_macros.svh"

module rgb_conv3x3_normalized import rcn_pkg::*; (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_tvalid,
   output logic                      req_tready,
   input  logic [PIX_BITS-1:0]       req_tdata,   // in_red, in_green, in_blue
   output logic                      rsp_tvalid,
   input  logic                      rsp_tready,
   // out_red, out_green, out_blue, out_col, out_row, zero pad
   output logic [47:0]               rsp_tdata,
   output logic                      rsp_tlast,   // frame_done
   input  logic                      csr_we,
   input  logic [CSR_ADDR_BITS-1:0]  csr_addr,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);
   cfg_type   cfg_ff;
   qctl_type  qctl;
   job_type   push_job, head_job;
   logic [PIX_BITS-1:0]  req_pix;
   logic [CHAN_BITS-1:0] out_red, out_green, out_blue;
   logic [COL_BITS-1:0]  out_col;
   logic [ROW_BITS-1:0]  out_row;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.frame_width  <= RESET_WIDTH;
         cfg_ff.frame_height <= RESET_HEIGHT;
         cfg_ff.kernel[0]    <= RESET_KTOP;
         cfg_ff.kernel[1]    <= RESET_KMID;
         cfg_ff.kernel[2]    <= RESET_KBOT;
      end else if (csr_we) begin
         case (csr_index_type'(csr_addr))
            CSR_FRAME_WIDTH:  cfg_ff.frame_width  <= csr_wdata[FW_BITS-1:0];
            CSR_FRAME_HEIGHT: cfg_ff.frame_height <= csr_wdata[FH_BITS-1:0];
            CSR_KERNEL_TOP:   cfg_ff.kernel[0]    <= csr_wdata[KROW_BITS-1:0];
            CSR_KERNEL_MID:   cfg_ff.kernel[1]    <= csr_wdata[KROW_BITS-1:0];
            CSR_KERNEL_BOT:   cfg_ff.kernel[2]    <= csr_wdata[KROW_BITS-1:0];
            default: begin
            end
         endcase
      end
   end

   // internal pixel word keeps red in the top byte
   assign req_pix = {req_tdata[7:0], req_tdata[15:8], req_tdata[23:16]};

   rcn_front u_front (
      .clock        (clock),
      .reset        (reset),
      .frame_width  (cfg_ff.frame_width),
      .frame_height (cfg_ff.frame_height),
      .pix_valid    (req_tvalid),
      .pix_ready    (req_tready),
      .pix          (req_pix),
      .q_full       (qctl.full),
      .q_push       (qctl.push),
      .q_job        (push_job)
   );

   rcn_queue u_queue (
      .clock  (clock),
      .reset  (reset),
      .ctl_in (qctl),
      .full   (qctl.full),
      .empty  (qctl.empty),
      .wr_job (push_job),
      .rd_job (head_job)
   );

   rcn_back u_back (
      .clock     (clock),
      .reset     (reset),
      .kernel    (cfg_ff.kernel),
      .q_empty   (qctl.empty),
      .q_job     (head_job),
      .q_pop     (qctl.pop),
      .rsp_valid (rsp_tvalid),
      .rsp_ready (rsp_tready),
      .rsp_red   (out_red),
      .rsp_green (out_green),
      .rsp_blue  (out_blue),
      .rsp_col   (out_col),
      .rsp_row   (out_row),
      .rsp_done  (rsp_tlast)
   );

   assign rsp_tdata = {1'b0, out_row, out_col, out_blue, out_green, out_red};

   `RCN_ASSERT(a_queue_no_overflow, clock, reset, qctl.push |-> !qctl.full, "job pushed into full queue")
   `RCN_ASSERT(a_queue_no_underflow, clock, reset, qctl.pop |-> !qctl.empty, "job popped from empty queue")
   `RCN_ASSERT(a_front_busy_after_accept, clock, reset, (req_tvalid && req_tready) |=> !req_tready, "front took a second item while loading")
   `RCN_ASSERT_ALWAYS(a_reset_clears_output, clock, reset |=> !rsp_tvalid, "output valid after reset")
endmodule
